FILE: hw/rtl/ssgk_pkg.sv
// shared types, codes and the glyph table of the scanning keyboard
`timescale 1ns / 1ps
package ssgk_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W     = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SHIFT = 2'd2;

	localparam logic [15:0] TIMEOUT_RST    = 16'd1500;
	localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
	localparam logic        AUTO_SHIFT_RST = 1'b1;

	// request modes
	localparam logic [1:0] MODE_PRESS   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;
	localparam logic [1:0] MODE_START   = 2'd3;

	// selection levels
	localparam logic [1:0] LVL_BLOCK = 2'd0;
	localparam logic [1:0] LVL_ROW   = 2'd1;
	localparam logic [1:0] LVL_CHAR  = 2'd2;

	localparam logic signed [2:0] SEL_NONE = -3'sd1;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [15:0] long_press_ms;
		logic        auto_shift;
	} cfg_t;

	typedef struct packed {
		logic               char_valid;
		logic [6:0]         char_out;
		logic [1:0]         level;
		logic signed [2:0]  block_sel;
		logic signed [2:0]  row_sel;
		logic signed [2:0]  char_sel;
		logic               shift_state;
		logic               redraw;
	} result_t;

	// 4 blocks x 3 rows x 3 characters, upper case
	function automatic logic [6:0] glyph(input logic [1:0] blk, input logic [1:0] row,
	                                     input logic [1:0] chr);
		logic [7:0] c;
		logic [5:0] key;
		key = {blk, row, chr};
		unique case (key)
			6'b00_00_00: c = "A";  6'b00_00_01: c = "B";  6'b00_00_10: c = "C";
			6'b00_01_00: c = "D";  6'b00_01_01: c = "E";  6'b00_01_10: c = "F";
			6'b00_10_00: c = "G";  6'b00_10_01: c = "H";  6'b00_10_10: c = "I";
			6'b01_00_00: c = "J";  6'b01_00_01: c = "K";  6'b01_00_10: c = "L";
			6'b01_01_00: c = "M";  6'b01_01_01: c = "N";  6'b01_01_10: c = "O";
			6'b01_10_00: c = "P";  6'b01_10_01: c = "Q";  6'b01_10_10: c = "R";
			6'b10_00_00: c = "S";  6'b10_00_01: c = "T";  6'b10_00_10: c = "U";
			6'b10_01_00: c = "V";  6'b10_01_01: c = "W";  6'b10_01_10: c = "X";
			6'b10_10_00: c = "Y";  6'b10_10_01: c = "Z";  6'b10_10_10: c = "?";
			6'b11_00_00: c = " ";  6'b11_00_01: c = ",";  6'b11_00_10: c = ".";
			6'b11_01_00: c = "(";  6'b11_01_01: c = "?";  6'b11_01_10: c = "!";
			6'b11_10_00: c = ")";  6'b11_10_01: c = ";";  6'b11_10_10: c = ":";
			default:     c = "A";
		endcase
		return c[6:0];
	endfunction

endpackage

FILE: hw/rtl/ssgk_cfg.sv
// configuration registers of the scanning keyboard
`timescale 1ns / 1ps
module ssgk_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [ssgk_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [ssgk_pkg::CFG_DATA_W-1:0] data,
	output ssgk_pkg::cfg_t                  cfg
);

	ssgk_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms    <= ssgk_pkg::TIMEOUT_RST;
			cfg_q.long_press_ms <= ssgk_pkg::LONG_PRESS_RST;
			cfg_q.auto_shift    <= ssgk_pkg::AUTO_SHIFT_RST;
		end else if (we) begin
			unique case (idx)
				ssgk_pkg::CFG_TIMEOUT:    cfg_q.timeout_ms    <= data;
				ssgk_pkg::CFG_LONG_PRESS: cfg_q.long_press_ms <= data;
				ssgk_pkg::CFG_AUTO_SHIFT: cfg_q.auto_shift    <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/ssgk_engine.sv
// selection state and its combinational update for one request
`timescale 1ns / 1ps
module ssgk_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssgk_pkg::cfg_t               cfg,
	input  logic                         req_en,
	input  logic [1:0]                   mode,
	input  logic [ssgk_pkg::TIME_W-1:0]  now_ms,
	input  logic [ssgk_pkg::TIME_W-1:0]  hold_ms,
	output ssgk_pkg::result_t            res
);

	logic [1:0]                  level_q, level_d;
	logic signed [2:0]           block_q, block_d;
	logic signed [2:0]           row_q, row_d;
	logic signed [2:0]           char_q, char_d;
	logic [ssgk_pkg::TIME_W-1:0] last_q, last_d;
	logic                        shift_q, shift_d;

	logic [ssgk_pkg::TIME_W-1:0] elapsed;
	logic                        tick_hit;
	logic [6:0]                  raw_c, adj_c;
	logic                        valid, redraw;

	assign elapsed  = now_ms - last_q;
	assign tick_hit = (last_q != '0) &&
	                  (elapsed >= {{(ssgk_pkg::TIME_W-16){1'b0}}, cfg.timeout_ms});
	assign raw_c    = ssgk_pkg::glyph(block_q[1:0], row_q[1:0], char_q[1:0]);

	always_comb begin
		level_d = level_q;
		block_d = block_q;
		row_d   = row_q;
		char_d  = char_q;
		last_d  = last_q;
		shift_d = shift_q;
		valid   = 1'b0;
		redraw  = 1'b0;
		adj_c   = raw_c;
		unique case (mode)
			ssgk_pkg::MODE_PRESS: last_d = now_ms;
			ssgk_pkg::MODE_RELEASE: begin
				if (hold_ms < {{(ssgk_pkg::TIME_W-16){1'b0}}, cfg.long_press_ms}) begin
					redraw = 1'b1;
					priority case (level_q)
						ssgk_pkg::LVL_BLOCK: begin
							if (block_q[2] || block_q == 3'sd3) block_d = 3'sd0;
							else block_d = 3'(block_q + 3'sd1);
						end
						ssgk_pkg::LVL_ROW: begin
							if (row_q[2]) row_d = 3'sd0;
							else if (row_q == 3'sd2) begin
								level_d = ssgk_pkg::LVL_BLOCK;
								block_d = ssgk_pkg::SEL_NONE;
								row_d   = ssgk_pkg::SEL_NONE;
								char_d  = ssgk_pkg::SEL_NONE;
							end else row_d = 3'(row_q + 3'sd1);
						end
						default: begin
							if (char_q[2]) char_d = 3'sd0;
							else if (char_q == 3'sd2) begin
								level_d = ssgk_pkg::LVL_BLOCK;
								block_d = ssgk_pkg::SEL_NONE;
								row_d   = ssgk_pkg::SEL_NONE;
								char_d  = ssgk_pkg::SEL_NONE;
							end else char_d = 3'(char_q + 3'sd1);
						end
					endcase
					last_d = now_ms;
				end
			end
			ssgk_pkg::MODE_TICK: begin
				if (tick_hit) begin
					redraw = 1'b1;
					last_d = '0;
					priority case (level_q)
						ssgk_pkg::LVL_BLOCK: begin
							if (!block_q[2]) begin
								level_d = ssgk_pkg::LVL_ROW;
								row_d   = ssgk_pkg::SEL_NONE;
								char_d  = ssgk_pkg::SEL_NONE;
							end
						end
						ssgk_pkg::LVL_ROW: begin
							if (!row_q[2]) begin
								level_d = ssgk_pkg::LVL_CHAR;
								char_d  = ssgk_pkg::SEL_NONE;
							end
						end
						default: begin
							if (!char_q[2]) begin
								valid = 1'b1;
								// table holds upper case; fold letters down without shift
								if (shift_q) begin
									if (cfg.auto_shift) shift_d = 1'b0;
								end else if (raw_c >= 7'h41 && raw_c <= 7'h5A) begin
									adj_c = 7'(raw_c + 7'h20);
								end
								if (adj_c == 7'h2E || adj_c == 7'h21 || adj_c == 7'h3F)
									shift_d = 1'b1;
								level_d = ssgk_pkg::LVL_BLOCK;
								block_d = ssgk_pkg::SEL_NONE;
								row_d   = ssgk_pkg::SEL_NONE;
								char_d  = ssgk_pkg::SEL_NONE;
							end
						end
					endcase
				end
			end
			default: begin
				level_d = ssgk_pkg::LVL_BLOCK;
				block_d = ssgk_pkg::SEL_NONE;
				row_d   = ssgk_pkg::SEL_NONE;
				char_d  = ssgk_pkg::SEL_NONE;
				last_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= ssgk_pkg::LVL_BLOCK;
			block_q <= ssgk_pkg::SEL_NONE;
			row_q   <= ssgk_pkg::SEL_NONE;
			char_q  <= ssgk_pkg::SEL_NONE;
			last_q  <= '0;
			shift_q <= 1'b0;
		end else if (req_en) begin
			level_q <= level_d;
			block_q <= block_d;
			row_q   <= row_d;
			char_q  <= char_d;
			last_q  <= last_d;
			shift_q <= shift_d;
		end
	end

	always_comb begin
		res.char_valid  = valid;
		res.char_out    = valid ? adj_c : 7'd0;
		res.level       = level_d;
		res.block_sel   = block_d;
		res.row_sel     = row_d;
		res.char_sel    = char_d;
		res.shift_state = shift_d;
		res.redraw      = redraw;
	end

endmodule

FILE: hw/rtl/single_switch_grid_scan_keyboard.sv
// top level of the single-switch grid scanning keyboard
// path: the input register, then the result register on the master side
// throughput: one request per cycle unless m_tready is low; selection state updates
//   in the cycle a request leaves the input register; the next one sees it at once
// reset: arst_n clears both stages, the selection to block level with nothing
//   highlighted, the press timestamp and shift, and loads the register defaults
`timescale 1ns / 1ps
module single_switch_grid_scan_keyboard (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [ssgk_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ssgk_pkg::CFG_DATA_W-1:0] cfg_data,
	// request side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,   // now_ms[31:0], hold_ms[63:32]
	input  logic [1:0]                      s_tuser,   // mode[1:0]
	// result side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,   // char_out[6:0], level[8:7],
	                                                   // block_sel[11:9], row_sel[14:12],
	                                                   // char_sel[17:15], shift_state[18],
	                                                   // redraw[19], zero[23:20]
	output logic [0:0]                      m_tuser    // char_valid[0]
);

	ssgk_pkg::cfg_t    cfg;
	ssgk_pkg::result_t res, res_q;

	// input register
	logic                        valid_s1;
	logic [1:0]                  mode_s1;
	logic [ssgk_pkg::TIME_W-1:0] now_s1, hold_s1;

	logic out_valid_q;
	logic advance;   // request in the input register moves to the result register

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	ssgk_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_tready) valid_s1 <= s_tvalid;
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			now_s1  <= s_tdata[31:0];
			hold_s1 <= s_tdata[63:32];
		end
	end

	// state advances only when the request is handed to the result register
	ssgk_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.req_en  (advance),
		.mode    (mode_s1),
		.now_ms  (now_s1),
		.hold_ms (hold_s1),
		.res     (res)
	);

	// result register, holds while the master side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (!out_valid_q || m_tready) out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.char_valid;
	assign m_tdata  = {4'd0, res_q.redraw, res_q.shift_state, res_q.char_sel,
	                   res_q.row_sel, res_q.block_sel, res_q.level, res_q.char_out};

endmodule
